// ===== rtl/crrm_pkg.sv =====
// shared types and constants for the chained range remap block
`default_nettype none

package crrm_pkg;

    localparam int CRRM_ENTRIES_PER_STAGE = 64;
    localparam int CRRM_STAGE_COUNT       = 7;

    localparam logic [1:0] STATUS_STORED  = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_LOOKUP  = 2'd2;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/chained_range_remap_min_top.sv =====
// chained interval remap tables with running minimum of lookup results
//
// Input transactions arrive on s_axis: tuser selects load or lookup and the
// stage, tdata carries source start, destination start and length. Every
// input transaction gives exactly one result transaction on m_axis: tuser is
// the status, tdata the final location and the lowest location seen so far.
// All range entries sit in one synchronous memory of STAGE_COUNT x
// ENTRIES_PER_STAGE words. A load writes its entry in S_LOAD, and its
// result then moves from S_DONE into the output register. A lookup streams
// the entries of each stage through the memory read port, one read per
// cycle, and stops early in a stage at the first hit; it then moves on to
// the next stage, and after the last stage its result goes out via S_DONE.
// One transaction is processed at a time; the next is accepted once the
// result has moved into the output register, even while that result waits.
// A stalled receiver holds the result and, once the next item is done,
// holds the block in its final state. Reset clears the fill counts, the
// minimum (to all ones) and all handshakes; no clearing pass is needed.
`default_nettype none

module chained_range_remap_min_top #(
    parameter int ENTRIES_PER_STAGE = crrm_pkg::CRRM_ENTRIES_PER_STAGE,
    parameter int STAGE_COUNT       = crrm_pkg::CRRM_STAGE_COUNT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [95:0] s_axis_tdata,   // source_value, map_dest, map_length
    input  wire  [3:0]  s_axis_tuser,   // req_type, stage
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // location, min_location
    output logic [1:0]  m_axis_tuser    // status
);

    import crrm_pkg::*;

    localparam int DEPTH = STAGE_COUNT * ENTRIES_PER_STAGE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIW   = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int FW    = $clog2(ENTRIES_PER_STAGE + 1);

    t_state r_state, n_state;

    logic              r_req;
    logic              r_drop;
    logic [SIW-1:0]    r_stage;
    logic [AW-1:0]     r_base;
    logic [FW-1:0]     r_k;
    logic              r_rd_valid;
    logic [95:0]       r_rd_data;
    logic [95:0]       r_in_data;
    logic [31:0]       r_value;
    logic [FW-1:0]     r_fill [STAGE_COUNT];
    logic [31:0]       r_lowest;
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [31:0]       r_out_loc;
    logic [31:0]       r_out_min;
    logic [1:0]        r_status;

    logic [95:0]       mem [DEPTH];

    logic              w_in_fire;
    logic [2:0]        w_in_stage;
    logic              w_out_free;
    logic [FW-1:0]     w_fill;
    logic              w_store;
    logic [31:0]       w_src;
    logic [31:0]       w_dst;
    logic [31:0]       w_len;
    logic [31:0]       w_diff;
    logic              w_hit;
    logic              w_adv;
    logic              w_issue;
    logic              w_last_stage;
    logic [31:0]       w_new_min;

    assign w_in_fire    = s_axis_tvalid && s_axis_tready;
    assign w_in_stage   = s_axis_tuser[3:1];
    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_fill       = (32'(r_stage) < STAGE_COUNT) ? r_fill[r_stage] : '0;
    assign w_store      = !r_drop && (w_fill < FW'(ENTRIES_PER_STAGE));
    assign w_src        = r_rd_data[31:0];
    assign w_dst        = r_rd_data[63:32];
    assign w_len        = r_rd_data[95:64];
    assign w_diff       = r_value - w_src;
    assign w_hit        = r_rd_valid && (r_value >= w_src) && (w_diff < w_len);
    assign w_adv        = w_hit || (r_k >= w_fill);
    assign w_issue      = !w_hit && (r_k < w_fill);
    assign w_last_stage = (32'(r_stage) == STAGE_COUNT - 1);
    assign w_new_min    = (r_req == REQ_LOOKUP && r_value < r_lowest) ? r_value : r_lowest;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (s_axis_tuser[0] == REQ_LOOKUP) ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD: n_state = S_DONE;
            S_SCAN: begin
                if (w_adv && w_last_stage) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = r_out_valid;
        m_axis_tuser  = r_out_status;
        m_axis_tdata  = {r_out_min, r_out_loc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_valid  <= 1'b0;
            r_lowest    <= '1;
            r_out_valid <= 1'b0;
            for (int i = 0; i < STAGE_COUNT; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_rd_valid <= 1'b0;
                end
                S_LOAD: begin
                    if (w_store) begin
                        r_fill[r_stage] <= w_fill + 1'b1;
                    end
                end
                S_SCAN: begin
                    r_rd_valid <= w_issue;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_lowest <= w_new_min;
                    end
                end
                default: r_rd_valid <= 1'b0;
            endcase
        end
    end

    // datapath without reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_req     <= s_axis_tuser[0];
                    r_in_data <= s_axis_tdata;
                    r_value   <= s_axis_tdata[31:0];
                    r_k       <= '0;
                    if (s_axis_tuser[0] == REQ_LOOKUP) begin
                        r_drop  <= 1'b0;
                        r_stage <= '0;
                        r_base  <= '0;
                    end else begin
                        r_drop  <= (32'(w_in_stage) >= STAGE_COUNT);
                        r_stage <= SIW'(w_in_stage);
                        r_base  <= AW'(AW'(SIW'(w_in_stage)) * AW'(ENTRIES_PER_STAGE));
                    end
                end
            end
            S_LOAD: begin
                r_status <= w_store ? STATUS_STORED : STATUS_DROPPED;
            end
            S_SCAN: begin
                r_status <= STATUS_LOOKUP;
                if (w_hit) begin
                    r_value <= w_dst + w_diff;
                end
                if (w_adv) begin
                    r_k <= '0;
                    if (!w_last_stage) begin
                        r_stage <= r_stage + 1'b1;
                        r_base  <= r_base + AW'(ENTRIES_PER_STAGE);
                    end
                end else if (w_issue) begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_status <= r_status;
                    r_out_loc    <= (r_req == REQ_LOOKUP) ? r_value : 32'd0;
                    r_out_min    <= w_new_min;
                end
            end
            default: r_k <= '0;
        endcase
    end

    // entry memory, one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && w_store) begin
            mem[r_base + AW'(w_fill)] <= r_in_data;
        end
        if (r_state == S_SCAN && w_issue) begin
            r_rd_data <= mem[r_base + AW'(r_k)];
        end
    end

endmodule

`default_nettype wire
